FILE: design/seg_pkg.sv
// Shared constants and the tolerance test for the segment intersection block.
`timescale 1ns / 1ps
`default_nettype none
package seg_pkg;

  localparam int TOL_W      = 32;
  localparam int SUM_MAX_W  = 67;
  localparam int FIFO_DEPTH = 4;

  localparam logic [TOL_W-1:0] TOL_RESET = 32'd256;

  // true when a product counts as zero: exactly zero or magnitude below tolerance
  function automatic logic tol_zero(logic signed [SUM_MAX_W-1:0] x,
                                    logic [TOL_W-1:0] tol);
    logic [SUM_MAX_W-1:0] mag;
    mag = x[SUM_MAX_W-1] ? SUM_MAX_W'(-x) : SUM_MAX_W'(x);
    return (x == '0) || (mag < {{(SUM_MAX_W-TOL_W){1'b0}}, tol});
  endfunction

endpackage
`default_nettype wire

FILE: design/seg_if.sv
// Channel interfaces: segment pair input, crossing result output, tolerance write.
`timescale 1ns / 1ps
`default_nettype none
interface seg_in_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_start_x;
  logic signed [COORD_WIDTH-1:0] first_start_y;
  logic signed [COORD_WIDTH-1:0] first_end_x;
  logic signed [COORD_WIDTH-1:0] first_end_y;
  logic signed [COORD_WIDTH-1:0] second_start_x;
  logic signed [COORD_WIDTH-1:0] second_start_y;
  logic signed [COORD_WIDTH-1:0] second_end_x;
  logic signed [COORD_WIDTH-1:0] second_end_y;
  logic                          first_bounded_start;
  logic                          first_bounded_end;
  logic                          second_bounded_start;
  logic                          second_bounded_end;

  modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y,
                  first_bounded_start, first_bounded_end, second_bounded_start,
                  second_bounded_end, input ready);
  modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                second_start_x, second_start_y, second_end_x, second_end_y,
                first_bounded_start, first_bounded_end, second_bounded_start,
                second_bounded_end, output ready);
endinterface

interface seg_out_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic                          crosses;
  logic                          parallel;
  logic signed [COORD_WIDTH-1:0] meet_x;
  logic signed [COORD_WIDTH-1:0] meet_y;
  logic                          saturated;

  modport source (output valid, crosses, parallel, meet_x, meet_y, saturated, input ready);
  modport sink (input valid, crosses, parallel, meet_x, meet_y, saturated, output ready);
endinterface

interface seg_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] tolerance;

  modport source (output valid, tolerance, input ready);
  modport sink (input valid, tolerance, output ready);
endinterface
`default_nettype wire

FILE: design/seg_front.sv
// Front end: takes segment pairs, forms cross products, classifies parallel and collinear.
`timescale 1ns / 1ps
`default_nettype none
module seg_front #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [seg_pkg::TOL_W-1:0]         tol_i,
  seg_in_if.sink                                 in_i,
  output logic                                   push_valid_o,
  input  wire logic                              push_ready_i,
  output logic [8*COORD_WIDTH+3:0]               pts_o,
  output logic signed [2*COORD_WIDTH+2:0]        num_o,
  output logic signed [2*COORD_WIDTH+2:0]        den_o,
  output logic                                   par_o,
  output logic                                   col_o
);
  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int SW    = PW + 1;
  localparam int PTS_W = 8 * CW + 4;
  localparam int NSTG  = 4;

  logic             adv;
  logic [NSTG-1:0]  vld_q;
  logic [PTS_W-1:0] pts_q [NSTG];
  logic [PTS_W-1:0] pts_d;

  logic signed [DW-1:0] abx_d, aby_d, cdx_d, cdy_d, acx_d, acy_d, bcx_d, bcy_d;
  logic signed [DW-1:0] abx_q, aby_q, cdx_q, cdy_q, acx_q, acy_q, bcx_q, bcy_q;
  logic signed [PW-1:0] pd0_q, pd1_q, pn0_q, pn1_q, pc0_q, pc1_q;
  logic signed [SW-1:0] den_q, num_q, col_q;
  logic signed [SW-1:0] den4_q, num4_q;
  logic                 par4_q, col4_q;

  assign adv       = !vld_q[NSTG-1] || push_ready_i;
  assign in_i.ready = adv;

  assign pts_d = {in_i.first_start_x, in_i.first_start_y, in_i.first_end_x, in_i.first_end_y,
                  in_i.second_start_x, in_i.second_start_y, in_i.second_end_x,
                  in_i.second_end_y, in_i.first_bounded_start, in_i.first_bounded_end,
                  in_i.second_bounded_start, in_i.second_bounded_end};

  assign abx_d = DW'(in_i.first_end_x) - DW'(in_i.first_start_x);
  assign aby_d = DW'(in_i.first_end_y) - DW'(in_i.first_start_y);
  assign cdx_d = DW'(in_i.second_end_x) - DW'(in_i.second_start_x);
  assign cdy_d = DW'(in_i.second_end_y) - DW'(in_i.second_start_y);
  assign acx_d = DW'(in_i.first_start_x) - DW'(in_i.second_start_x);
  assign acy_d = DW'(in_i.first_start_y) - DW'(in_i.second_start_y);
  assign bcx_d = DW'(in_i.first_end_x) - DW'(in_i.second_start_x);
  assign bcy_d = DW'(in_i.first_end_y) - DW'(in_i.second_start_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pts_q[0] <= pts_d;
      for (int k = 1; k < NSTG; k++) begin
        pts_q[k] <= pts_q[k-1];
      end
      abx_q <= abx_d;
      aby_q <= aby_d;
      cdx_q <= cdx_d;
      cdy_q <= cdy_d;
      acx_q <= acx_d;
      acy_q <= acy_d;
      bcx_q <= bcx_d;
      bcy_q <= bcy_d;
      pd0_q <= PW'(abx_q) * PW'(cdy_q);
      pd1_q <= PW'(aby_q) * PW'(cdx_q);
      pn0_q <= PW'(cdx_q) * PW'(acy_q);
      pn1_q <= PW'(cdy_q) * PW'(acx_q);
      pc0_q <= PW'(acx_q) * PW'(bcy_q);
      pc1_q <= PW'(acy_q) * PW'(bcx_q);
      den_q <= SW'(pd0_q) - SW'(pd1_q);
      num_q <= SW'(pn0_q) - SW'(pn1_q);
      col_q <= SW'(pc0_q) - SW'(pc1_q);
      den4_q <= den_q;
      num4_q <= num_q;
      par4_q <= seg_pkg::tol_zero(seg_pkg::SUM_MAX_W'(den_q), tol_i);
      col4_q <= seg_pkg::tol_zero(seg_pkg::SUM_MAX_W'(col_q), tol_i);
    end
  end

  assign push_valid_o = vld_q[NSTG-1];
  assign pts_o        = pts_q[NSTG-1];
  assign num_o        = num4_q;
  assign den_o        = den4_q;
  assign par_o        = par4_q;
  assign col_o        = col4_q;

endmodule
`default_nettype wire

FILE: design/seg_fifo.sv
// Short queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module seg_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);
  localparam int AW   = $clog2(seg_pkg::FIFO_DEPTH);
  localparam int CNTW = AW + 1;

  logic [WIDTH-1:0] mem_q [seg_pkg::FIFO_DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CNTW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNTW'(seg_pkg::FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + AW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + AW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: design/seg_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`timescale 1ns / 1ps
`default_nettype none
module seg_div #(
  parameter int NW = 53,
  parameter int SW = 35,
  parameter int QW = 17
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [SW-1:0] den_i,
  output logic [QW-1:0]      quo_o,
  output logic               ovf_o
);
  logic [NW-1:0] rem_q [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  logic [SW-1:0] d_q   [QW];
  logic          ovf_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      d_q[0]   <= den_i;
      q_q[0]   <= '0;
      ovf_q[0] <= num_i >= (NW'(den_i) << QW);
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    localparam int B = QW - j;
    logic [NW-1:0] t;
    logic          ge;
    assign t  = NW'(d_q[j-1]) << B;
    assign ge = rem_q[j-1] >= t;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? rem_q[j-1] - t : rem_q[j-1];
        q_q[j]   <= q_q[j-1] | (QW'(ge) << B);
        ovf_q[j] <= ovf_q[j-1];
      end
    end
    if (j < QW) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          d_q[j] <= d_q[j-1];
        end
      end
    end
  end

  assign quo_o = q_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule
`default_nettype wire

FILE: design/seg_back.sv
// Back end: crossing point division, rounding, clamping and on-line tests.
`timescale 1ns / 1ps
`default_nettype none
module seg_back #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [seg_pkg::TOL_W-1:0]         tol_i,
  input  wire logic                              pop_valid_i,
  output logic                                   pop_ready_o,
  input  wire logic [8*COORD_WIDTH+3:0]          pts_i,
  input  wire logic signed [2*COORD_WIDTH+2:0]   num_i,
  input  wire logic signed [2*COORD_WIDTH+2:0]   den_i,
  input  wire logic                              par_i,
  input  wire logic                              col_i,
  seg_out_if.source                              out_o
);
  localparam int CW      = COORD_WIDTH;
  localparam int DW      = CW + 1;
  localparam int PW      = 2 * DW;
  localparam int SW      = PW + 1;
  localparam int QW      = CW + 1;
  localparam int NW      = DW + SW + 1;
  localparam int HL      = (SW + 1) / 2;
  localparam int HH      = SW - HL;
  localparam int RW      = CW + 3;
  localparam int DIV_LAT = QW + 1;
  localparam int S5      = 3 + DIV_LAT;
  localparam int S8      = S5 + 3;
  localparam int NST     = S5 + 5;

  localparam logic signed [RW-1:0] C_HI = (RW'(1) << (CW - 1)) - RW'(1);
  localparam logic signed [RW-1:0] C_LO = -C_HI - RW'(1);

  typedef struct packed {
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic                 cut_a, cut_b, cut_c, cut_d;
    logic                 par, col, neg_x, neg_y;
    logic signed [CW-1:0] mx, my;
    logic                 sat;
  } sb_t;

  logic           adv;
  logic [NST-1:0] vld_q;
  sb_t            sb_q [NST];
  sb_t            sb0_d, sb5_d;

  logic signed [DW-1:0] abx, aby;
  logic [DW-1:0]        adx_q, ady_q;
  logic [SW-1:0]        anum_q, aden_q, aden2_q, half_q, aden3_q;
  logic [DW+HL-1:0]     pxl_q, pyl_q;
  logic [DW+HH-1:0]     pxh_q, pyh_q;
  logic [NW-1:0]        nx_q, ny_q;
  logic [QW-1:0]        qx, qy;
  logic                 ovfx, ovfy;

  logic signed [RW-1:0] rx, ry;
  logic                 clx, cly;

  logic signed [DW-1:0] sp_x_q [2], sp_y_q [2], ep_x_q [2], ep_y_q [2];
  logic signed [DW-1:0] dd_x_q [2], dd_y_q [2];
  logic signed [PW-1:0] c0_q [2], c1_q [2], s0_q [2], s1_q [2], e0_q [2], e1_q [2];
  logic signed [SW-1:0] cr_q [2], ds_q [2], de_q [2];
  logic                 on_ok [2];

  logic                 crosses_q, parallel_q, sat_q;
  logic signed [CW-1:0] mx_q, my_q;

  assign adv         = !vld_q[NST-1] || out_o.ready;
  assign pop_ready_o = adv;

  always_comb begin
    sb0_d       = '0;
    sb0_d.ax    = pts_i[4+7*CW +: CW];
    sb0_d.ay    = pts_i[4+6*CW +: CW];
    sb0_d.bx    = pts_i[4+5*CW +: CW];
    sb0_d.by    = pts_i[4+4*CW +: CW];
    sb0_d.cx    = pts_i[4+3*CW +: CW];
    sb0_d.cy    = pts_i[4+2*CW +: CW];
    sb0_d.dx    = pts_i[4+CW +: CW];
    sb0_d.dy    = pts_i[4 +: CW];
    sb0_d.cut_a = pts_i[3];
    sb0_d.cut_b = pts_i[2];
    sb0_d.cut_c = pts_i[1];
    sb0_d.cut_d = pts_i[0];
    sb0_d.par   = par_i;
    sb0_d.col   = col_i;
    abx         = DW'(sb0_d.bx) - DW'(sb0_d.ax);
    aby         = DW'(sb0_d.by) - DW'(sb0_d.ay);
    sb0_d.neg_x = abx[DW-1] ^ num_i[SW-1] ^ den_i[SW-1];
    sb0_d.neg_y = aby[DW-1] ^ num_i[SW-1] ^ den_i[SW-1];
  end

  seg_div #(.NW(NW), .SW(SW), .QW(QW)) u_div_x (
    .clk_i (clk_i), .en_i (adv), .num_i (nx_q), .den_i (aden3_q),
    .quo_o (qx), .ovf_o (ovfx)
  );

  seg_div #(.NW(NW), .SW(SW), .QW(QW)) u_div_y (
    .clk_i (clk_i), .en_i (adv), .num_i (ny_q), .den_i (aden3_q),
    .quo_o (qy), .ovf_o (ovfy)
  );

  // round-half-away offset applied to A, then clamp to coordinate range
  always_comb begin
    sb5_d = sb_q[S5-1];
    rx    = sb5_d.neg_x ? RW'(sb5_d.ax) - signed'(RW'(qx)) : RW'(sb5_d.ax) + signed'(RW'(qx));
    ry    = sb5_d.neg_y ? RW'(sb5_d.ay) - signed'(RW'(qy)) : RW'(sb5_d.ay) + signed'(RW'(qy));
    clx   = ovfx || (rx > C_HI) || (rx < C_LO);
    cly   = ovfy || (ry > C_HI) || (ry < C_LO);
    if (ovfx) begin
      sb5_d.mx = sb5_d.neg_x ? CW'(C_LO) : CW'(C_HI);
    end else if (rx > C_HI) begin
      sb5_d.mx = CW'(C_HI);
    end else if (rx < C_LO) begin
      sb5_d.mx = CW'(C_LO);
    end else begin
      sb5_d.mx = CW'(rx);
    end
    if (ovfy) begin
      sb5_d.my = sb5_d.neg_y ? CW'(C_LO) : CW'(C_HI);
    end else if (ry > C_HI) begin
      sb5_d.my = CW'(C_HI);
    end else if (ry < C_LO) begin
      sb5_d.my = CW'(C_LO);
    end else begin
      sb5_d.my = CW'(ry);
    end
    sb5_d.sat = clx || cly;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], pop_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q[0] <= sb0_d;
      for (int k = 1; k < NST; k++) begin
        if (k == S5) begin
          sb_q[k] <= sb5_d;
        end else begin
          sb_q[k] <= sb_q[k-1];
        end
      end
      adx_q   <= abx[DW-1] ? DW'(-abx) : DW'(abx);
      ady_q   <= aby[DW-1] ? DW'(-aby) : DW'(aby);
      anum_q  <= num_i[SW-1] ? SW'(-num_i) : SW'(num_i);
      aden_q  <= den_i[SW-1] ? SW'(-den_i) : SW'(den_i);
      pxl_q   <= (DW+HL)'(adx_q) * (DW+HL)'(anum_q[HL-1:0]);
      pxh_q   <= (DW+HH)'(adx_q) * (DW+HH)'(anum_q[SW-1:HL]);
      pyl_q   <= (DW+HL)'(ady_q) * (DW+HL)'(anum_q[HL-1:0]);
      pyh_q   <= (DW+HH)'(ady_q) * (DW+HH)'(anum_q[SW-1:HL]);
      half_q  <= aden_q >> 1;
      aden2_q <= aden_q;
      nx_q    <= (NW'(pxh_q) << HL) + NW'(pxl_q) + NW'(half_q);
      ny_q    <= (NW'(pyh_q) << HL) + NW'(pyl_q) + NW'(half_q);
      aden3_q <= aden2_q;
    end
  end

  // on-line tests: line one is A to B, line two is C to D
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sp_x_q[0] <= DW'(sb_q[S5].mx) - DW'(sb_q[S5].ax);
      sp_y_q[0] <= DW'(sb_q[S5].my) - DW'(sb_q[S5].ay);
      ep_x_q[0] <= DW'(sb_q[S5].mx) - DW'(sb_q[S5].bx);
      ep_y_q[0] <= DW'(sb_q[S5].my) - DW'(sb_q[S5].by);
      dd_x_q[0] <= DW'(sb_q[S5].bx) - DW'(sb_q[S5].ax);
      dd_y_q[0] <= DW'(sb_q[S5].by) - DW'(sb_q[S5].ay);
      sp_x_q[1] <= DW'(sb_q[S5].mx) - DW'(sb_q[S5].cx);
      sp_y_q[1] <= DW'(sb_q[S5].my) - DW'(sb_q[S5].cy);
      ep_x_q[1] <= DW'(sb_q[S5].mx) - DW'(sb_q[S5].dx);
      ep_y_q[1] <= DW'(sb_q[S5].my) - DW'(sb_q[S5].dy);
      dd_x_q[1] <= DW'(sb_q[S5].dx) - DW'(sb_q[S5].cx);
      dd_y_q[1] <= DW'(sb_q[S5].dy) - DW'(sb_q[S5].cy);
      for (int l = 0; l < 2; l++) begin
        c0_q[l] <= PW'(sp_x_q[l]) * PW'(ep_y_q[l]);
        c1_q[l] <= PW'(sp_y_q[l]) * PW'(ep_x_q[l]);
        s0_q[l] <= PW'(sp_x_q[l]) * PW'(dd_x_q[l]);
        s1_q[l] <= PW'(sp_y_q[l]) * PW'(dd_y_q[l]);
        e0_q[l] <= PW'(dd_x_q[l]) * PW'(ep_x_q[l]);
        e1_q[l] <= PW'(dd_y_q[l]) * PW'(ep_y_q[l]);
        cr_q[l] <= SW'(c0_q[l]) - SW'(c1_q[l]);
        ds_q[l] <= SW'(s0_q[l]) + SW'(s1_q[l]);
        de_q[l] <= SW'(e0_q[l]) + SW'(e1_q[l]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      on_ok[l] = seg_pkg::tol_zero(seg_pkg::SUM_MAX_W'(cr_q[l]), tol_i);
      if ((l == 0 ? sb_q[S8].cut_a : sb_q[S8].cut_c) && ds_q[l][SW-1] &&
          !seg_pkg::tol_zero(seg_pkg::SUM_MAX_W'(ds_q[l]), tol_i)) begin
        on_ok[l] = 1'b0;
      end
      if ((l == 0 ? sb_q[S8].cut_b : sb_q[S8].cut_d) && !de_q[l][SW-1] &&
          !seg_pkg::tol_zero(seg_pkg::SUM_MAX_W'(de_q[l]), tol_i)) begin
        on_ok[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      parallel_q <= sb_q[S8].par;
      crosses_q  <= sb_q[S8].par ? sb_q[S8].col : (on_ok[0] && on_ok[1]);
      mx_q       <= sb_q[S8].par ? sb_q[S8].ax : sb_q[S8].mx;
      my_q       <= sb_q[S8].par ? sb_q[S8].ay : sb_q[S8].my;
      sat_q      <= !sb_q[S8].par && sb_q[S8].sat;
    end
  end

  assign out_o.valid     = vld_q[NST-1];
  assign out_o.crosses   = crosses_q;
  assign out_o.parallel  = parallel_q;
  assign out_o.meet_x    = mx_q;
  assign out_o.meet_y    = my_q;
  assign out_o.saturated = sat_q;

endmodule
`default_nettype wire

FILE: design/segment_intersection.sv
// Segment intersection top level: tolerance register, front end, queue and back end.
//
// Takes one pair of lines per cycle and returns one result beat per pair, in order,
// as long as out_o is not stalled: throughput is then one beat per clock. The
// crossing point is formed by a bit-per-stage restoring divider (COORD_WIDTH + 2
// stages). The tolerance register resets to 256 and is written through the cfg
// channel, which is always ready; write it only while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  seg_cfg_if.sink    cfg_i,
  seg_in_if.sink     in_i,
  seg_out_if.source  out_o
);
  localparam int SW    = 2 * COORD_WIDTH + 3;
  localparam int PTS_W = 8 * COORD_WIDTH + 4;
  localparam int FW    = PTS_W + 2 * SW + 2;

  logic [seg_pkg::TOL_W-1:0] tol_q;

  logic                 f_valid, f_ready, b_valid, b_ready;
  logic [PTS_W-1:0]     f_pts;
  logic signed [SW-1:0] f_num, f_den;
  logic                 f_par, f_col;
  logic [FW-1:0]        q_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= seg_pkg::TOL_RESET;
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.tolerance;
    end
  end

  seg_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tol_i        (tol_q),
    .in_i         (in_i),
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .pts_o        (f_pts),
    .num_o        (f_num),
    .den_o        (f_den),
    .par_o        (f_par),
    .col_o        (f_col)
  );

  seg_fifo #(.WIDTH(FW)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_pts, f_num, f_den, f_par, f_col}),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_data)
  );

  seg_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_i       (tol_q),
    .pop_valid_i (b_valid),
    .pop_ready_o (b_ready),
    .pts_i       (q_data[FW-1 -: PTS_W]),
    .num_i       (q_data[2*SW+1 -: SW]),
    .den_i       (q_data[SW+1 -: SW]),
    .par_i       (q_data[1]),
    .col_i       (q_data[0]),
    .out_o       (out_o)
  );

`ifndef NO_ASSERTIONS
  localparam logic signed [COORD_WIDTH-1:0] M_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] M_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  a_par_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.parallel |-> !out_o.saturated)
    else $error("saturated set on a parallel result");

  a_sat_at_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      (out_o.meet_x == M_HI || out_o.meet_x == M_LO ||
       out_o.meet_y == M_HI || out_o.meet_y == M_LO))
    else $error("saturated result not at range limit");

  a_cfg_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid |=> tol_q == $past(cfg_i.tolerance))
    else $error("tolerance write lost");
`endif

endmodule
`default_nettype wire
